FILE: rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// shared types and constants for the pen-based midpoint line rasterizer
// ----------------------------------------------------------------------------
package lrp_pkg;

   localparam int COORD_BITS = 12;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int COLOR_BITS = 24;

   localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_MOVE = 2'd0,
      CMD_LINE = 2'd1,
      CMD_STEP = 2'd2
   } cmd_type;

   // bit 0 of step_signs: x steps down, bit 1: y steps down
   typedef struct packed {
      logic signed [COORD_BITS-1:0] pen_x;
      logic signed [COORD_BITS-1:0] pen_y;
      logic signed [COORD_BITS-1:0] cursor_x;
      logic signed [COORD_BITS-1:0] cursor_y;
      logic signed [COORD_BITS-1:0] major_end;
      logic        [COORD_BITS-1:0] major_delta;
      logic        [COORD_BITS-1:0] minor_delta;
      logic signed [ERR_BITS-1:0]   error_term;
      logic        [1:0]            step_signs;
      logic                         y_is_major;
      logic                         drawing;
   } pen_state_type;

   typedef struct packed {
      logic                         emit;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
   } pixel_type;

endpackage

FILE: rtl/lrp_stepper.sv
// ----------------------------------------------------------------------------
// lrp_stepper
// next pen state and plotted pixel for one command beat
// ----------------------------------------------------------------------------
module lrp_stepper
   import lrp_pkg::*;
(
   input  logic [1:0]                   cmd,
   input  logic signed [COORD_BITS-1:0] target_x,
   input  logic signed [COORD_BITS-1:0] target_y,
   input  pen_state_type                cur,
   output pen_state_type                nxt,
   output pixel_type                    pix
);

   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic        [COORD_BITS:0]   adx_w;
   logic        [COORD_BITS:0]   ady_w;
   logic        [COORD_BITS-1:0] adx;
   logic        [COORD_BITS-1:0] ady;
   logic                         ymaj;
   logic        [COORD_BITS-1:0] major;
   logic        [COORD_BITS-1:0] minor;
   logic signed [ERR_BITS-1:0]   err_init;
   logic signed [ERR_BITS-1:0]   err_add;
   logic signed [ERR_BITS-1:0]   err_step;
   logic                         minor_step;
   logic signed [COORD_BITS-1:0] x_adv;
   logic signed [COORD_BITS-1:0] y_adv;
   logic signed [COORD_BITS-1:0] new_x;
   logic signed [COORD_BITS-1:0] new_y;
   logic                         step_last;

   // line setup
   always_comb begin
      dx    = {target_x[COORD_BITS-1], target_x} - {cur.pen_x[COORD_BITS-1], cur.pen_x};
      dy    = {target_y[COORD_BITS-1], target_y} - {cur.pen_y[COORD_BITS-1], cur.pen_y};
      adx_w = dx[COORD_BITS] ? -dx : dx;
      ady_w = dy[COORD_BITS] ? -dy : dy;
      adx   = adx_w[COORD_BITS-1:0];
      ady   = ady_w[COORD_BITS-1:0];
      ymaj  = !(adx > ady);
      major = ymaj ? ady : adx;
      minor = ymaj ? adx : ady;
      err_init = $signed({2'b00, minor}) - $signed({3'b000, major[COORD_BITS-1:1]});
   end

   // one midpoint step
   always_comb begin
      minor_step = !cur.error_term[ERR_BITS-1];
      err_add    = cur.error_term + $signed({2'b00, cur.minor_delta});
      err_step   = minor_step ? err_add - $signed({2'b00, cur.major_delta}) : err_add;
      x_adv      = cur.step_signs[0] ? cur.cursor_x - 1'b1 : cur.cursor_x + 1'b1;
      y_adv      = cur.step_signs[1] ? cur.cursor_y - 1'b1 : cur.cursor_y + 1'b1;
      if (cur.y_is_major) begin
         new_y     = y_adv;
         new_x     = minor_step ? x_adv : cur.cursor_x;
         step_last = (y_adv == cur.major_end);
      end else begin
         new_x     = x_adv;
         new_y     = minor_step ? y_adv : cur.cursor_y;
         step_last = (x_adv == cur.major_end);
      end
   end

   always_comb begin
      nxt      = cur;
      pix.emit = 1'b0;
      pix.x    = cur.cursor_x;
      pix.y    = cur.cursor_y;
      pix.last = 1'b0;
      unique case (cmd_type'(cmd))
         CMD_MOVE: begin
            nxt.pen_x   = target_x;
            nxt.pen_y   = target_y;
            nxt.drawing = 1'b0;
         end
         CMD_LINE: begin
            nxt.step_signs  = {dy[COORD_BITS], dx[COORD_BITS]};
            nxt.y_is_major  = ymaj;
            nxt.major_delta = major;
            nxt.minor_delta = minor;
            nxt.major_end   = ymaj ? target_y : target_x;
            nxt.error_term  = err_init;
            nxt.cursor_x    = cur.pen_x;
            nxt.cursor_y    = cur.pen_y;
            nxt.pen_x       = target_x;
            nxt.pen_y       = target_y;
            nxt.drawing     = (major != '0);
            pix.emit        = 1'b1;
            pix.x           = cur.pen_x;
            pix.y           = cur.pen_y;
            pix.last        = (major == '0);
         end
         CMD_STEP: begin
            if (cur.drawing) begin
               nxt.error_term = err_step;
               nxt.cursor_x   = new_x;
               nxt.cursor_y   = new_y;
               nxt.drawing    = !step_last;
               pix.emit       = 1'b1;
               pix.x          = new_x;
               pix.y          = new_y;
               pix.last       = step_last;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/line_rasterizer_pen.sv
// ----------------------------------------------------------------------------
// line_rasterizer_pen
// midpoint line generator with a pen, all eight octants
//
//   channel  dir  handshake                 payload
//   req_     in   req_valid / req_ready     req_cmd, req_target_x, req_target_y
//   rsp_     out  rsp_valid / rsp_ready     rsp_pixel_x, rsp_pixel_y,
//                                           rsp_pixel_color, rsp_last_pixel
//   csr_     in   csr_valid / csr_ready     csr_draw_color
//
// one command beat per cycle while req_ready is high; a pixel appears in the cycle after its beat
// the per-cycle limit is the error update and cursor add of the stepper
// req_ready drops only while a pixel waits in the output register
// move, unused commands and steps while idle produce no pixel
// reset is synchronous; pen, cursor and line state clear, color goes white
// ----------------------------------------------------------------------------
module line_rasterizer_pen
   import lrp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic signed [COORD_BITS-1:0] req_target_x,
   input  logic signed [COORD_BITS-1:0] req_target_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                         rsp_last_pixel,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [COLOR_BITS-1:0]        csr_draw_color
);

   pen_state_type                state_ff;
   pen_state_type                state_in;
   pixel_type                    pix;
   logic [COLOR_BITS-1:0]        color_ff;
   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] pix_x_ff;
   logic signed [COORD_BITS-1:0] pix_y_ff;
   logic [COLOR_BITS-1:0]        pix_color_ff;
   logic                         pix_last_ff;
   logic                         req_beat;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   lrp_stepper u_stepper (
      .cmd      (req_cmd),
      .target_x (req_target_x),
      .target_y (req_target_y),
      .cur      (state_ff),
      .nxt      (state_in),
      .pix      (pix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            color_ff <= csr_draw_color;
         end
         if (req_beat) begin
            state_ff     <= state_in;
            rsp_valid_ff <= pix.emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && pix.emit) begin
         pix_x_ff     <= pix.x;
         pix_y_ff     <= pix.y;
         pix_color_ff <= color_ff;
         pix_last_ff  <= pix.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_pixel_color = pix_color_ff;
   assign rsp_last_pixel  = pix_last_ff;

   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_cmd == CMD_STEP) && !state_ff.drawing |=> !rsp_valid)
      else $error("step while idle produced a pixel");

   a_line_starts_at_pen: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_cmd == CMD_LINE) |=>
         rsp_valid && (rsp_pixel_x == $past(state_ff.pen_x))
                   && (rsp_pixel_y == $past(state_ff.pen_y)))
      else $error("line beat did not emit the pen position");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_pixel != state_ff.drawing))
      else $error("last flag disagrees with drawing state");

   a_move_aborts: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_cmd == CMD_MOVE) |=> !state_ff.drawing && !rsp_valid)
      else $error("move beat left a line running");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pen-based midpoint line rasterizer
//
// commands come from a pending queue and go through a clocked driver that
// inserts random gaps. Each accepted beat runs through a pen and line model
// that is kept here, and any pixel it yields waits in a queue. A clocked
// monitor stalls the pixel channel at random and compares every pixel with
// the oldest waiting one. Directed beats cover zero-length lines, steps
// while idle, aborts, unused commands and a color change in the middle of a
// line. Random phases then draw short polylines in all octants, plus some
// aborted and overrun lines and some long ones, each under its own color.
// ----------------------------------------------------------------------------
module tb_top;
   import lrp_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RESET_CYCLES = 6;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         PHASE_BEATS  = 175;

   typedef struct {
      logic [1:0]                   cmd;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } pen_cmd_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]        color;
      logic                         last;
   } pixel_rec_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_cmd = CMD_MOVE;
   logic signed [COORD_BITS-1:0] req_target_x = '0;
   logic signed [COORD_BITS-1:0] req_target_y = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_pixel_x;
   logic signed [COORD_BITS-1:0] rsp_pixel_y;
   logic [COLOR_BITS-1:0]        rsp_pixel_color;
   logic                         rsp_last_pixel;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [COLOR_BITS-1:0]        csr_draw_color = '0;

   line_rasterizer_pen dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_draw_color  (csr_draw_color)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // pen and line model
   logic [COLOR_BITS-1:0] ink = COLOR_RESET;
   int pen_x = 0, pen_y = 0, dot_x = 0, dot_y = 0, run_end = 0;
   int run_len = 0, side_len = 0, mid_err = 0;
   bit x_back = 0, y_back = 0, steep = 0, busy = 0;

   pen_cmd_type   pending[$];
   pixel_rec_type pixel_q[$];
   pen_cmd_type   next_cmd;

   int beats_queued = 0, beats_done = 0, lines_queued = 0;
   int pixels_seen = 0, color_writes = 0, mismatches = 0;
   int gen_x = 0, gen_y = 0, line_span = 0;
   int req_gap = 0, req_calm = 0, rsp_stall = 0, rsp_calm = 0;

   task automatic push_pixel(input bit done);
      pixel_rec_type p;
      p.x = dot_x[COORD_BITS-1:0];
      p.y = dot_y[COORD_BITS-1:0];
      p.color = ink;
      p.last = done;
      pixel_q.insert(pixel_q.size(), p);
   endtask

   task automatic predict_beat(input logic [1:0] cmd,
                               input logic signed [COORD_BITS-1:0] tx,
                               input logic signed [COORD_BITS-1:0] ty);
      int dx, dy, adx, ady;
      bit minor_move, done;
      case (cmd)
         CMD_MOVE: begin
            pen_x = tx;
            pen_y = ty;
            busy = 0;
         end
         CMD_LINE: begin
            dx = int'(tx) - pen_x;
            dy = int'(ty) - pen_y;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            x_back = dx < 0;
            y_back = dy < 0;
            steep = !(adx > ady);
            if (steep) begin
               run_len = ady;
               side_len = adx;
               run_end = ty;
            end else begin
               run_len = adx;
               side_len = ady;
               run_end = tx;
            end
            mid_err = side_len - run_len / 2;
            dot_x = pen_x;
            dot_y = pen_y;
            pen_x = tx;
            pen_y = ty;
            busy = run_len != 0;
            push_pixel(!busy);
         end
         CMD_STEP: begin
            if (busy) begin
               if (mid_err < 0) begin
                  mid_err += side_len;
                  minor_move = 0;
               end else begin
                  mid_err += side_len - run_len;
                  minor_move = 1;
               end
               if (steep) begin
                  dot_y += y_back ? -1 : 1;
                  if (minor_move) dot_x += x_back ? -1 : 1;
                  done = dot_y == run_end;
               end else begin
                  dot_x += x_back ? -1 : 1;
                  if (minor_move) dot_y += y_back ? -1 : 1;
                  done = dot_x == run_end;
               end
               busy = !done;
               push_pixel(done);
            end
         end
         default: ;
      endcase
   endtask

   // mostly short gaps, a few long ones, and runs with none at all
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 80);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_beat(req_cmd, req_target_x, req_target_y);
            beats_done++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               next_cmd = pending.pop_front();
               req_cmd <= next_cmd.cmd;
               req_target_x <= next_cmd.x;
               req_target_y <= next_cmd.y;
               req_valid <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pixel_rec_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
               $error("pixel with no expectation at (%0d,%0d)", rsp_pixel_x, rsp_pixel_y);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  $error("pixel_x: expected %0d, got %0d", want.x, rsp_pixel_x);
                  mismatches++;
               end
               if (rsp_pixel_y !== want.y) begin
                  $error("pixel_y: expected %0d, got %0d", want.y, rsp_pixel_y);
                  mismatches++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color: expected %06h, got %06h", want.color, rsp_pixel_color);
                  mismatches++;
               end
               if (rsp_last_pixel !== want.last) begin
                  $error("last_pixel: expected %0d, got %0d", want.last, rsp_last_pixel);
                  mismatches++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap(rsp_calm);
         end
      end
   end

   // stimulus side keeps its own idea of the pen to size the step runs
   task automatic queue_cmd(input logic [1:0] cmd, input int x, input int y);
      pen_cmd_type item;
      int ax, ay;
      item.cmd = cmd;
      item.x = x[COORD_BITS-1:0];
      item.y = y[COORD_BITS-1:0];
      if (cmd == CMD_LINE) begin
         ax = int'(item.x) - gen_x;
         ay = int'(item.y) - gen_y;
         if (ax < 0) ax = -ax;
         if (ay < 0) ay = -ay;
         line_span = ax > ay ? ax : ay;
         lines_queued++;
      end
      if (cmd == CMD_MOVE || cmd == CMD_LINE) begin
         gen_x = item.x;
         gen_y = item.y;
      end
      pending.insert(pending.size(), item);
      beats_queued++;
   endtask

   function automatic int rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return -2048;
      if (r < 16) return 2047;
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (beats_done != beats_queued || pixel_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_color(input logic [COLOR_BITS-1:0] value);
      wait_idle();
      csr_draw_color <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      ink = value;
      color_writes++;
   endtask

   task automatic random_phase(input int count);
      int stop, r, n;
      stop = beats_queued + count;
      while (beats_queued < stop) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            queue_cmd($urandom_range(0, 1) ? CMD_STEP : CMD_UNUSED, rand_coord(), rand_coord());
         end else begin
            if (r < 35) queue_cmd(CMD_MOVE, rand_coord(), rand_coord());
            r = $urandom_range(0, 99);
            if (r < 80)
               queue_cmd(CMD_LINE, gen_x + int'($urandom_range(0, 24)) - 12,
                         gen_y + int'($urandom_range(0, 24)) - 12);
            else if (r < 95)
               queue_cmd(CMD_LINE, gen_x + int'($urandom_range(0, 600)) - 300,
                         gen_y + int'($urandom_range(0, 600)) - 300);
            else
               queue_cmd(CMD_LINE, rand_coord(), rand_coord());
            n = line_span;
            r = $urandom_range(0, 99);
            if (r < 15) n = $urandom_range(0, n);
            else if (r < 25) n = n + $urandom_range(1, 3);
            // long lines get cut short by the next command
            if (n > 40) n = $urandom_range(5, 40);
            repeat (n) begin
               if ($urandom_range(0, 99) < 3)
                  queue_cmd(CMD_UNUSED, rand_coord(), rand_coord());
               queue_cmd(CMD_STEP, rand_coord(), rand_coord());
            end
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle steps, unused command, zero-length line, abort, then a line
      // left open across a color change
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_UNUSED, -1, -1);
      queue_cmd(CMD_LINE, 0, 0);
      queue_cmd(CMD_STEP, 2047, 2047);
      queue_cmd(CMD_MOVE, -2048, 2047);
      queue_cmd(CMD_LINE, 2047, -2048);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_UNUSED, 0, 0);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_MOVE, 0, 0);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_LINE, 3, -1);
      queue_cmd(CMD_STEP, 0, 0);
      write_color(24'h000000);
      queue_cmd(CMD_STEP, -1, -1);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_LINE, -1, 2);
      repeat (4) queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_LINE, -2048, -2048);
      queue_cmd(CMD_STEP, 0, 0);
      queue_cmd(CMD_LINE, -2048, -2048);
      queue_cmd(CMD_STEP, 0, 0);

      for (int p = 0; p < 5; p++) begin
         if (p == 0) write_color(24'hFFFFFF);
         else write_color($urandom_range(0, 24'hFFFFFF));
         random_phase(PHASE_BEATS);
      end

      do @(posedge clock);
      while (beats_done != beats_queued);
      for (int i = 0; i < 2000 && pixel_q.size() != 0; i++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixel_q.size() != 0) begin
         $error("%0d expected pixels never arrived", pixel_q.size());
         mismatches += pixel_q.size();
      end

      $display("drew %0d lines from %0d command beats, %0d pixels compared",
               lines_queued, beats_done, pixels_seen);
      $display("%0d color writes, %0d mismatches", color_writes, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d of %0d beats accepted", beats_done, beats_queued);
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
rtl/lrp_pkg.sv
rtl/lrp_stepper.sv
rtl/line_rasterizer_pen.sv
tb/tb_top.sv
